[rtl/core/id_pool_allocator_top_defines.svh]
// Assertion macros shared by the id pool allocator RTL.
`ifndef ID_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define ID_POOL_ALLOCATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ipa_pkg.sv]
// Shared types and constants of the id pool allocator.
package ipa_pkg;

    localparam int DEF_POOL_DEPTH  = 256;
    localparam int DEF_HANDLE_BITS = 64;

    localparam int ACTION_W = 2;
    localparam int ID_PORT_W = 8;
    localparam int VALUE_W = 64;
    localparam int STATUS_W = 2;
    localparam int TDATA_W = 80;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic {
        CTRL_IDLE = 1'b0,
        CTRL_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

    typedef struct packed {
        logic out_valid;
    } dp_stat_t;

endpackage

[rtl/core/ipa_ctrl.sv]
// Controller state machine of the id pool allocator.
module ipa_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    input  ipa_pkg::dp_stat_t stat,
    output ipa_pkg::dp_cmd_t  cmd
);

    ipa_pkg::ctrl_state_t state_reg;
    ipa_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ipa_pkg::CTRL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            ipa_pkg::CTRL_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ipa_pkg::CTRL_EXEC;
                end
            end
            ipa_pkg::CTRL_EXEC:
            begin
                if (!stat.out_valid || out_ready)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ipa_pkg::CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = ipa_pkg::CTRL_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/ipa_datapath.sv]
// Datapath of the id pool allocator: handle table, free stack, counters and result register.
module ipa_datapath
#(
    parameter int POOL_DEPTH  = ipa_pkg::DEF_POOL_DEPTH,
    parameter int HANDLE_BITS = ipa_pkg::DEF_HANDLE_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ipa_pkg::dp_cmd_t               cmd,
    output ipa_pkg::dp_stat_t              stat,
    input  logic [ipa_pkg::ACTION_W-1:0]   in_action,
    input  logic [ipa_pkg::ID_PORT_W-1:0]  in_item_id,
    input  logic [ipa_pkg::VALUE_W-1:0]    in_handle_value,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [ipa_pkg::ID_PORT_W-1:0]  out_assigned_id,
    output logic [ipa_pkg::VALUE_W-1:0]    out_found_value,
    output logic [ipa_pkg::STATUS_W-1:0]   out_status
);

    localparam int ID_W  = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W = (CNT_W > ipa_pkg::ID_PORT_W) ? CNT_W : ipa_pkg::ID_PORT_W;

    logic [HANDLE_BITS-1:0] entry_mem [POOL_DEPTH];
    logic [ID_W-1:0]        stack_mem [POOL_DEPTH];

    logic [HANDLE_BITS-1:0] entry_rd_reg;
    logic [ID_W-1:0]        stack_rd_reg;

    logic [ipa_pkg::ACTION_W-1:0]  act_reg;
    logic [ipa_pkg::ID_PORT_W-1:0] id_reg;
    logic [HANDLE_BITS-1:0]        hnd_reg;

    logic [CNT_W-1:0] free_count_reg;
    logic [CNT_W-1:0] free_count_next;
    logic [CNT_W-1:0] high_water_reg;
    logic [CNT_W-1:0] high_water_next;

    logic                          out_valid_reg;
    logic [ipa_pkg::ID_PORT_W-1:0] out_id_reg;
    logic [ipa_pkg::ID_PORT_W-1:0] out_id_next;
    logic [ipa_pkg::VALUE_W-1:0]   out_val_reg;
    logic [ipa_pkg::VALUE_W-1:0]   out_val_next;
    logic [ipa_pkg::STATUS_W-1:0]  out_st_reg;
    logic [ipa_pkg::STATUS_W-1:0]  out_st_next;

    logic                   ent_we;
    logic [ID_W-1:0]        ent_wa;
    logic [HANDLE_BITS-1:0] ent_wd;
    logic                   stk_we;
    logic [ID_W-1:0]        stk_wa;
    logic [ID_W-1:0]        slot;
    logic                   live;

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[ent_wa] <= ent_wd;
        end
        if (cmd.capture)
        begin
            entry_rd_reg <= entry_mem[ID_W'(in_item_id)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_wa] <= ID_W'(id_reg);
        end
        if (cmd.capture)
        begin
            stack_rd_reg <= stack_mem[ID_W'(free_count_reg - CNT_W'(1))];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= in_action;
            id_reg  <= in_item_id;
            hnd_reg <= in_handle_value[HANDLE_BITS-1:0];
        end
        if (cmd.execute)
        begin
            out_id_reg  <= out_id_next;
            out_val_reg <= out_val_next;
            out_st_reg  <= out_st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg <= '0;
            high_water_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.execute)
            begin
                free_count_reg <= free_count_next;
                high_water_reg <= high_water_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign live = (CMP_W'(id_reg) < CMP_W'(high_water_reg)) && (entry_rd_reg != '0);

    always_comb
    begin
        free_count_next = free_count_reg;
        high_water_next = high_water_reg;
        out_id_next     = id_reg;
        out_val_next    = '0;
        out_st_next     = ipa_pkg::ST_OK;
        ent_we          = 1'b0;
        ent_wa          = ID_W'(id_reg);
        ent_wd          = '0;
        stk_we          = 1'b0;
        stk_wa          = ID_W'(free_count_reg);
        slot            = stack_rd_reg;
        case (act_reg)
            ipa_pkg::ACT_ADD:
            begin
                ent_wd = hnd_reg;
                if (free_count_reg != '0)
                begin
                    slot            = stack_rd_reg;
                    free_count_next = free_count_reg - CNT_W'(1);
                    ent_we          = cmd.execute;
                    out_id_next     = ipa_pkg::ID_PORT_W'(slot);
                end
                else if (high_water_reg < CNT_W'(POOL_DEPTH))
                begin
                    slot            = ID_W'(high_water_reg);
                    high_water_next = high_water_reg + CNT_W'(1);
                    ent_we          = cmd.execute;
                    out_id_next     = ipa_pkg::ID_PORT_W'(slot);
                end
                else
                begin
                    out_id_next = '0;
                    out_st_next = ipa_pkg::ST_FULL;
                end
                ent_wa = slot;
            end
            ipa_pkg::ACT_REMOVE:
            begin
                if (live && (free_count_reg < CNT_W'(POOL_DEPTH)))
                begin
                    ent_we          = cmd.execute;
                    stk_we          = cmd.execute;
                    free_count_next = free_count_reg + CNT_W'(1);
                end
                else
                begin
                    out_st_next = ipa_pkg::ST_UNKNOWN;
                end
            end
            ipa_pkg::ACT_LOOKUP:
            begin
                if (live)
                begin
                    out_val_next = ipa_pkg::VALUE_W'(entry_rd_reg);
                end
                else
                begin
                    out_st_next = ipa_pkg::ST_UNKNOWN;
                end
            end
            default:
            begin
                out_st_next = ipa_pkg::ST_UNKNOWN;
            end
        endcase
    end

    assign stat.out_valid  = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign out_assigned_id = out_id_reg;
    assign out_found_value = out_val_reg;
    assign out_status      = out_st_reg;

endmodule

[rtl/core/id_pool_allocator_top.sv]
// Top level of the id pool allocator: stream ports, controller and datapath.
// Each word has a capture step and an execute step: on acceptance the handle table and the
// free stack are read into registers; once the output register is free, the result is formed,
// the memories are written as the action requires, the result register is loaded and the input
// is ready again. A result waits in the output register while the next word is accepted, and a
// stalled output holds off only the next execute step. No clearing pass runs after reset.
`include "id_pool_allocator_top_defines.svh"

module id_pool_allocator_top
#(
    parameter int POOL_DEPTH  = ipa_pkg::DEF_POOL_DEPTH,
    parameter int HANDLE_BITS = ipa_pkg::DEF_HANDLE_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // action [1:0], item_id [9:2], handle_value [73:10], zeros [79:74]
    input  logic [ipa_pkg::TDATA_W-1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // assigned_id [7:0], found_value [71:8], status [73:72], zeros [79:74]
    output logic [ipa_pkg::TDATA_W-1:0] m_tdata
);

    ipa_pkg::dp_cmd_t  cmd;
    ipa_pkg::dp_stat_t stat;

    logic [ipa_pkg::ID_PORT_W-1:0] assigned_id;
    logic [ipa_pkg::VALUE_W-1:0]   found_value;
    logic [ipa_pkg::STATUS_W-1:0]  status;

    ipa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ipa_datapath
    #(
        .POOL_DEPTH  (POOL_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_action       (s_tdata[1:0]),
        .in_item_id      (s_tdata[9:2]),
        .in_handle_value (s_tdata[73:10]),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_assigned_id (assigned_id),
        .out_found_value (found_value),
        .out_status      (status)
    );

    assign m_tdata = {6'b0, status, found_value, assigned_id};

    `IPA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    `IPA_ASSERT_SAME(a_exec_slot_free, cmd.execute, !m_tvalid || m_tready, "result overwritten")
    `IPA_ASSERT_NEXT(a_exec_gives_word, cmd.execute, m_tvalid, "result not presented")
    `IPA_ASSERT_SAME(a_full_id_zero, m_tvalid && (status == ipa_pkg::ST_FULL),
                     assigned_id == '0, "full pool with nonzero id")

endmodule
